// ===== rtl/esd_pkg.sv =====
// ----------------------------------------------------------------------------
// esd_pkg
// Shared types, constants and the escape letter map for the escape decoder.
// ----------------------------------------------------------------------------
package esd_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   // '0' through '7' share these upper bits
   localparam logic [4:0] OCTAL_PREFIX   = 5'b00110;

   localparam logic [7:0] CHAR_A = 8'h61;
   localparam logic [7:0] CHAR_B = 8'h62;
   localparam logic [7:0] CHAR_F = 8'h66;
   localparam logic [7:0] CHAR_N = 8'h6E;
   localparam logic [7:0] CHAR_R = 8'h72;
   localparam logic [7:0] CHAR_T = 8'h74;
   localparam logic [7:0] CHAR_V = 8'h76;

   localparam logic [7:0] CODE_BEL = 8'd7;
   localparam logic [7:0] CODE_BS  = 8'd8;
   localparam logic [7:0] CODE_FF  = 8'd12;
   localparam logic [7:0] CODE_LF  = 8'd10;
   localparam logic [7:0] CODE_CR  = 8'd13;
   localparam logic [7:0] CODE_HT  = 8'd9;
   localparam logic [7:0] CODE_VT  = 8'd11;

   typedef enum logic [3:0] {
      MODE_PLAIN = 4'b0001,
      MODE_ESC   = 4'b0010,
      MODE_OCT1  = 4'b0100,
      MODE_OCT2  = 4'b1000
   } mode_type;

   // one queue entry holds the one or two words caused by a single input byte
   typedef struct packed {
      logic [7:0] byte0;
      logic       last0;
      logic       two;
      logic [7:0] byte1;
      logic       last1;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } slot_type;

   function automatic logic [7:0] map_escape(input logic [7:0] c);
      logic [7:0] r;
      unique case (c)
         CHAR_A:  r = CODE_BEL;
         CHAR_B:  r = CODE_BS;
         CHAR_F:  r = CODE_FF;
         CHAR_N:  r = CODE_LF;
         CHAR_R:  r = CODE_CR;
         CHAR_T:  r = CODE_HT;
         CHAR_V:  r = CODE_VT;
         default: r = c;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/esd_front.sv =====
// ----------------------------------------------------------------------------
// esd_front
// Takes source bytes, tracks escape state and builds queue entries.
// ----------------------------------------------------------------------------
module esd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        req_byte,
   output esd_pkg::slot_type push
);
   import esd_pkg::*;

   mode_type   mode_ff, mode_in;
   logic [7:0] oct_ff, oct_in;
   logic       is_oct;
   logic [2:0] digit;
   logic       flush, do_plain;
   logic       main_valid, main_last;
   logic [7:0] main_byte;

   always_comb begin
      is_oct     = (req_byte[7:3] == OCTAL_PREFIX);
      digit      = req_byte[2:0];
      flush      = 1'b0;
      do_plain   = 1'b0;
      main_valid = 1'b0;
      main_byte  = req_byte;
      main_last  = 1'b0;
      mode_in    = mode_ff;
      oct_in     = oct_ff;
      unique case (mode_ff)
         MODE_PLAIN: begin
            do_plain = 1'b1;
         end
         MODE_ESC: begin
            if (req_byte == CHAR_NUL) begin
               do_plain = 1'b1;
            end else if (is_oct) begin
               oct_in  = {5'b0, digit};
               mode_in = MODE_OCT1;
            end else begin
               main_valid = 1'b1;
               main_byte  = map_escape(req_byte);
               mode_in    = MODE_PLAIN;
            end
         end
         MODE_OCT1: begin
            if (is_oct) begin
               oct_in  = {oct_ff[4:0], digit};
               mode_in = MODE_OCT2;
            end else begin
               flush    = 1'b1;
               do_plain = 1'b1;
               oct_in   = 8'd0;
            end
         end
         MODE_OCT2: begin
            if (is_oct) begin
               // third digit: emit now, upper bits fall off
               main_valid = 1'b1;
               main_byte  = {oct_ff[4:0], digit};
               oct_in     = 8'd0;
               mode_in    = MODE_PLAIN;
            end else begin
               flush    = 1'b1;
               do_plain = 1'b1;
               oct_in   = 8'd0;
            end
         end
         default: begin
            mode_in = MODE_PLAIN;
            oct_in  = 8'd0;
         end
      endcase

      if (do_plain) begin
         if (req_byte == CHAR_NUL) begin
            main_valid = 1'b1;
            main_byte  = CHAR_NUL;
            main_last  = 1'b1;
            mode_in    = MODE_PLAIN;
            oct_in     = 8'd0;
         end else if (req_byte == CHAR_BACKSLASH) begin
            mode_in = MODE_ESC;
         end else begin
            main_valid = 1'b1;
            mode_in    = MODE_PLAIN;
         end
      end

      push.valid = accept && (flush || main_valid);
      if (flush) begin
         push.entry.byte0 = oct_ff;
         push.entry.last0 = 1'b0;
         push.entry.two   = main_valid;
      end else begin
         push.entry.byte0 = main_byte;
         push.entry.last0 = main_last;
         push.entry.two   = 1'b0;
      end
      push.entry.byte1 = main_byte;
      push.entry.last1 = main_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
         oct_ff  <= 8'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         oct_ff  <= oct_in;
      end
   end

endmodule

// ===== rtl/esd_queue.sv =====
// ----------------------------------------------------------------------------
// esd_queue
// Small entry queue between the classifying front and the output back end.
// ----------------------------------------------------------------------------
module esd_queue #(
   parameter int QUEUE_DEPTH = esd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  esd_pkg::slot_type push,
   input  logic              pop,
   output esd_pkg::slot_type head,
   output logic              full
);
   import esd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   entry_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push.valid && full))
      else $error("entry pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && (count_ff == '0)))
      else $error("pop from empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count out of range");

endmodule

// ===== rtl/esd_back.sv =====
// ----------------------------------------------------------------------------
// esd_back
// Drains queue entries into the output register, one word per cycle while rsp_stall is low.
// ----------------------------------------------------------------------------
module esd_back (
   input  logic              clock,
   input  logic              reset,
   input  esd_pkg::slot_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_byte,
   output logic              rsp_last
);
   import esd_pkg::*;

   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_last_ff;
   logic       sub_ff, sub_in;
   logic       load;

   // output register is free when empty or being taken this cycle
   assign load = !rsp_valid_ff || !rsp_stall;
   assign pop  = load && head.valid && (sub_ff || !head.entry.two);

   always_comb begin
      sub_in = sub_ff;
      if (load && head.valid) begin
         sub_in = !sub_ff && head.entry.two;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sub_ff       <= 1'b0;
      end else begin
         sub_ff <= sub_in;
         if (load) begin
            rsp_valid_ff <= head.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && head.valid) begin
         rsp_byte_ff <= sub_ff ? head.entry.byte1 : head.entry.byte0;
         rsp_last_ff <= sub_ff ? head.entry.last1 : head.entry.last0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_byte  = rsp_byte_ff;
   assign rsp_last  = rsp_last_ff;

   a_sub_has_second: assert property (@(posedge clock) disable iff (reset)
      sub_ff |-> (head.valid && head.entry.two))
      else $error("second word pending without a two-word entry");

   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("entry retired without a word in the output register");

endmodule

// ===== rtl/escape_sequence_decoder.sv =====
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// Streaming decoder of C-style backslash escapes in zero-terminated strings.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_stall/req_byte carry one source byte per word; a zero byte
//   ends the string. rsp_valid/rsp_stall/rsp_byte/rsp_last carry decoded
//   bytes; the string closes with a zero byte that has rsp_last set.
//   A source byte can cause zero, one or two words (a pending octal value is
//   flushed ahead of the byte that ends it).
// Path: each word is written into the queue when its source byte is taken and
//   is loaded from the queue head into the output register when that is free.
// Throughput: one source byte per cycle while req_stall is low. The output
//   port moves one word per cycle when not stalled, so a two-word byte holds
//   it longer; a queue of QUEUE_DEPTH entries between front and back absorbs it.
// Stall: when the receiver stalls, the output register holds its word, the
//   queue fills, and req_stall rises once the queue is full.
// Reset: synchronous, active high; empties the queue and the output register
//   and returns the decoder to plain text mode.
// ----------------------------------------------------------------------------
module escape_sequence_decoder #(
   parameter int QUEUE_DEPTH = esd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_byte,
   output logic       rsp_last
);
   import esd_pkg::*;

   slot_type push;
   slot_type head;
   logic     pop;
   logic     full;
   logic     accept;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   esd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_byte (req_byte),
      .push     (push)
   );

   esd_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (full)
   );

   esd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_byte  (rsp_byte),
      .rsp_last  (rsp_last)
   );

endmodule

// ===== test/tb_escape_sequence_decoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_escape_sequence_decoder
// Self-checking bench for the C-style escape decoder. A short stimulus table
// hits each escape letter and the octal corner cases. Random strings follow,
// mostly well-formed with some noise bytes. Each output word is compared with
// a typed row's words or a behavioral decoder kept in step with the input.
// ----------------------------------------------------------------------------
module tb_escape_sequence_decoder;
   import esd_pkg::*;

   localparam int DIRECTED_ROWS  = 25;
   localparam int TOTAL_ITEMS    = 1350;
   localparam int PHASE_ITEMS    = 160;
   localparam int HOLDOFF_START  = DIRECTED_ROWS + 10;
   localparam int HOLDOFF_CYCLES = 60;
   localparam int DRAIN_CYCLES   = 16;
   localparam int TIMEOUT_NS     = 400000;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } out_word_type;

   // one source byte; typed rows carry their expected words
   typedef struct packed {
      logic [7:0] data;
      logic       typed;
      logic [1:0] count;
      logic [7:0] w0_data;
      logic       w0_last;
      logic [7:0] w1_data;
      logic       w1_last;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_byte;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_byte;
   logic       rsp_last;

   stim_row_type  directed_table [DIRECTED_ROWS];
   stim_row_type  stim_q [$];
   out_word_type  expected_words [$];

   // behavioral decoder state
   mode_type      dec_mode;
   logic [7:0]    dec_octal;
   out_word_type  step_words [2];
   int            step_count;

   idle_mode_type idle_phase;
   logic          holdoff_go;
   logic          receiver_hold;

   int failures;
   int words_checked;
   int strings_closed;
   int double_steps;
   int held_input_cycles;

   escape_sequence_decoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_byte  (req_byte),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_byte  (rsp_byte),
      .rsp_last  (rsp_last)
   );

   always #1 clock = ~clock;

   task automatic emit_word(input logic [7:0] d, input logic l);
      step_words[step_count].data = d;
      step_words[step_count].last = l;
      step_count++;
   endtask

   task automatic take_plain(input logic [7:0] c);
      if (c == CHAR_NUL) begin
         emit_word(CHAR_NUL, 1'b1);
         dec_mode  = MODE_PLAIN;
         dec_octal = 8'h00;
      end else if (c == CHAR_BACKSLASH) begin
         dec_mode = MODE_ESC;
      end else begin
         dec_mode = MODE_PLAIN;
         emit_word(c, 1'b0);
      end
   endtask

   // advance the decoder by one source byte, leaving its words in step_words
   task automatic decode_model(input logic [7:0] c);
      logic is_digit;
      logic [7:0] code;
      is_digit   = (c[7:3] == OCTAL_PREFIX);
      step_count = 0;
      case (dec_mode)
         MODE_PLAIN: begin
            take_plain(c);
         end
         MODE_ESC: begin
            if (c == CHAR_NUL) begin
               take_plain(c);
            end else if (is_digit) begin
               dec_octal = {5'b00000, c[2:0]};
               dec_mode  = MODE_OCT1;
            end else begin
               case (c)
                  CHAR_A:  code = CODE_BEL;
                  CHAR_B:  code = CODE_BS;
                  CHAR_F:  code = CODE_FF;
                  CHAR_N:  code = CODE_LF;
                  CHAR_R:  code = CODE_CR;
                  CHAR_T:  code = CODE_HT;
                  CHAR_V:  code = CODE_VT;
                  default: code = c;
               endcase
               dec_mode = MODE_PLAIN;
               emit_word(code, 1'b0);
            end
         end
         MODE_OCT1: begin
            if (is_digit) begin
               dec_octal = {dec_octal[4:0], c[2:0]};
               dec_mode  = MODE_OCT2;
            end else begin
               emit_word(dec_octal, 1'b0);
               dec_octal = 8'h00;
               take_plain(c);
            end
         end
         default: begin
            if (is_digit) begin
               // third digit: value is cut to 8 bits
               emit_word({dec_octal[4:0], c[2:0]}, 1'b0);
               dec_octal = 8'h00;
               dec_mode  = MODE_PLAIN;
            end else begin
               emit_word(dec_octal, 1'b0);
               dec_octal = 8'h00;
               take_plain(c);
            end
         end
      endcase
   endtask

   task automatic push_byte(input logic [7:0] c);
      stim_row_type row;
      row       = '0;
      row.data  = c;
      row.typed = 1'b0;
      stim_q.push_back(row);
   endtask

   task automatic add_random_string();
      int n_tokens;
      int kind;
      int digits;
      int t;
      int d;
      logic [7:0] c;
      n_tokens = $urandom_range(0, 10);
      for (t = 0; t < n_tokens; t++) begin
         kind = $urandom_range(0, 99);
         if (kind < 40) begin
            c = 8'($urandom_range(1, 255));
            if (c == CHAR_BACKSLASH) push_byte(CHAR_BACKSLASH);
            push_byte(c);
         end else if (kind < 55) begin
            push_byte(CHAR_BACKSLASH);
            case ($urandom_range(0, 6))
               0:       push_byte(CHAR_A);
               1:       push_byte(CHAR_B);
               2:       push_byte(CHAR_F);
               3:       push_byte(CHAR_N);
               4:       push_byte(CHAR_R);
               5:       push_byte(CHAR_T);
               default: push_byte(CHAR_V);
            endcase
         end else if (kind < 65) begin
            push_byte(CHAR_BACKSLASH);
            push_byte(8'($urandom_range(1, 255)));
         end else if (kind < 90) begin
            push_byte(CHAR_BACKSLASH);
            digits = $urandom_range(1, 3);
            for (d = 0; d < digits; d++) push_byte({OCTAL_PREFIX, 3'($urandom_range(0, 7))});
         end else begin
            // noise, may end the string early
            push_byte(8'($urandom_range(0, 255)));
         end
      end
      if ($urandom_range(0, 15) == 0) push_byte(CHAR_BACKSLASH);
      push_byte(CHAR_NUL);
   endtask

   // compare outgoing words and pick the receiver stall for the next cycle
   always @(posedge clock) begin : check_words
      out_word_type head;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("unexpected word: rsp_byte %02h rsp_last %0b", rsp_byte, rsp_last);
            failures++;
         end else begin
            head = expected_words.pop_front();
            words_checked++;
            if (head.last) strings_closed++;
            if (rsp_byte !== head.data) begin
               $error("rsp_byte: expected %02h, got %02h", head.data, rsp_byte);
               failures++;
            end
            if (rsp_last !== head.last) begin
               $error("rsp_last: expected %0b, got %0b", head.last, rsp_last);
               failures++;
            end
         end
      end
      if (receiver_hold && req_stall) held_input_cycles++;
      if (receiver_hold)
         rsp_stall <= 1'b1;
      else if (idle_phase == IDLE_RECEIVER)
         rsp_stall <= ($urandom_range(0, 99) < 51);
      else if (idle_phase == IDLE_BOTH)
         rsp_stall <= ($urandom_range(0, 99) < 33);
      else
         rsp_stall <= 1'b0;
   end

   // long receiver hold-off so the queue fills and the input stalls
   initial begin : long_holdoff
      int n;
      receiver_hold <= 1'b0;
      wait (holdoff_go);
      @(posedge clock);
      receiver_hold <= 1'b1;
      for (n = 0; n < HOLDOFF_CYCLES; n++) @(posedge clock);
      receiver_hold <= 1'b0;
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("timeout with %0d words still expected", expected_words.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : drive_bytes
      int idx;
      int k;
      logic idle;
      stim_row_type row;
      out_word_type w;

      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_byte   <= 8'h00;
      idle_phase <= IDLE_NONE;
      holdoff_go <= 1'b0;
      failures          = 0;
      words_checked     = 0;
      strings_closed    = 0;
      double_steps      = 0;
      held_input_cycles = 0;
      dec_mode  = MODE_PLAIN;
      dec_octal = 8'h00;

      // data, typed, count, first word, second word
      directed_table = '{
         '{CHAR_BACKSLASH, 1'b1, 2'd0, CHAR_NUL, 1'b0, CHAR_NUL, 1'b0},
         '{8'hFF,          1'b1, 2'd1, 8'hFF,    1'b0, CHAR_NUL, 1'b0},
         '{CHAR_BACKSLASH, 1'b1, 2'd0, CHAR_NUL, 1'b0, CHAR_NUL, 1'b0},
         '{CHAR_A,         1'b1, 2'd1, CODE_BEL, 1'b0, CHAR_NUL, 1'b0},
         '{CHAR_BACKSLASH, 1'b1, 2'd0, CHAR_NUL, 1'b0, CHAR_NUL, 1'b0},
         '{CHAR_B,         1'b1, 2'd1, CODE_BS,  1'b0, CHAR_NUL, 1'b0},
         '{CHAR_BACKSLASH, 1'b1, 2'd0, CHAR_NUL, 1'b0, CHAR_NUL, 1'b0},
         '{CHAR_F,         1'b1, 2'd1, CODE_FF,  1'b0, CHAR_NUL, 1'b0},
         '{CHAR_BACKSLASH, 1'b1, 2'd0, CHAR_NUL, 1'b0, CHAR_NUL, 1'b0},
         '{CHAR_N,         1'b1, 2'd1, CODE_LF,  1'b0, CHAR_NUL, 1'b0},
         '{CHAR_BACKSLASH, 1'b1, 2'd0, CHAR_NUL, 1'b0, CHAR_NUL, 1'b0},
         '{CHAR_R,         1'b1, 2'd1, CODE_CR,  1'b0, CHAR_NUL, 1'b0},
         '{CHAR_BACKSLASH, 1'b1, 2'd0, CHAR_NUL, 1'b0, CHAR_NUL, 1'b0},
         '{CHAR_T,         1'b1, 2'd1, CODE_HT,  1'b0, CHAR_NUL, 1'b0},
         '{CHAR_BACKSLASH, 1'b1, 2'd0, CHAR_NUL, 1'b0, CHAR_NUL, 1'b0},
         '{CHAR_V,         1'b1, 2'd1, CODE_VT,  1'b0, CHAR_NUL, 1'b0},
         // three octal sevens, value cut to 8 bits
         '{CHAR_BACKSLASH,          1'b0, 2'd0, CHAR_NUL, 1'b0, CHAR_NUL, 1'b0},
         '{{OCTAL_PREFIX, 3'd7},    1'b0, 2'd0, CHAR_NUL, 1'b0, CHAR_NUL, 1'b0},
         '{{OCTAL_PREFIX, 3'd7},    1'b0, 2'd0, CHAR_NUL, 1'b0, CHAR_NUL, 1'b0},
         '{{OCTAL_PREFIX, 3'd7},    1'b0, 2'd0, CHAR_NUL, 1'b0, CHAR_NUL, 1'b0},
         // escaped zero digit flushed by the end of string
         '{CHAR_BACKSLASH,          1'b1, 2'd0, CHAR_NUL, 1'b0, CHAR_NUL, 1'b0},
         '{{OCTAL_PREFIX, 3'd0},    1'b1, 2'd0, CHAR_NUL, 1'b0, CHAR_NUL, 1'b0},
         '{CHAR_NUL,                1'b1, 2'd2, CHAR_NUL, 1'b0, CHAR_NUL, 1'b1},
         // dangling backslash is dropped
         '{CHAR_BACKSLASH,          1'b1, 2'd0, CHAR_NUL, 1'b0, CHAR_NUL, 1'b0},
         '{CHAR_NUL,                1'b1, 2'd1, CHAR_NUL, 1'b1, CHAR_NUL, 1'b0}
      };
      for (idx = 0; idx < DIRECTED_ROWS; idx++) stim_q.push_back(directed_table[idx]);
      while (stim_q.size() < TOTAL_ITEMS) add_random_string();

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (!reset);

      idx = 0;
      while (idx < stim_q.size()) begin
         @(posedge clock);
         if (req_valid && !req_stall) begin
            row = stim_q[idx];
            decode_model(row.data);
            if (row.typed) begin
               if (row.count > 0) begin
                  w.data = row.w0_data;
                  w.last = row.w0_last;
                  expected_words.push_back(w);
               end
               if (row.count > 1) begin
                  w.data = row.w1_data;
                  w.last = row.w1_last;
                  expected_words.push_back(w);
                  double_steps++;
               end
            end else begin
               for (k = 0; k < step_count; k++) expected_words.push_back(step_words[k]);
               if (step_count == 2) double_steps++;
            end
            idx++;
         end
         if (idx < DIRECTED_ROWS)
            idle_phase <= IDLE_NONE;
         else
            idle_phase <= idle_mode_type'(((idx - DIRECTED_ROWS) / PHASE_ITEMS) % 4);
         if (idx == HOLDOFF_START) holdoff_go <= 1'b1;
         idle = (idle_phase == IDLE_SENDER && $urandom_range(0, 99) < 51) ||
                (idle_phase == IDLE_BOTH && $urandom_range(0, 99) < 33);
         if (idx == stim_q.size()) begin
            req_valid <= 1'b0;
         end else if (req_valid && req_stall) begin
            // stalled word stays on the bus
         end else if (idle) begin
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_byte  <= stim_q[idx].data;
         end
      end

      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("decoded %0d source bytes into %0d words over %0d strings",
               stim_q.size(), words_checked, strings_closed);
      $display("%0d bytes gave two words; input held off %0d cycles during the long stall",
               double_steps, held_input_cycles);
      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
